/* src/oal_pkg.sv */
package oal_pkg;

    localparam int CAPACITY = 128;

    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int FIDX_W  = 7;
    localparam int COUNT_W = 8;
    localparam int ACT_W   = 2;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

/* src/oal_ram.sv */
module oal_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/ordered_array_list_engine.sv */
// channel   | signals                                  | transfer
// ----------+------------------------------------------+---------------------------
// request   | action, position, value                  | start high while busy low
// result    | status, item_out, found_index, count     | done high, one cycle
//
// entries sit in a single memory with one read and one write port, one entry
// per cycle: insert moves the entries from position on up, then writes the
// value (no moves when appending); delete moves later entries down one;
// search reads from index 0 to a hit or the end; errors go straight to done
// reset clears length and control only; the memory contents are not cleared
// busy stays high until the cycle after done; results are never held back
module ordered_array_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [oal_pkg::ACT_W-1:0]         action,
    input  logic [oal_pkg::POS_W-1:0]         position,
    input  logic signed [oal_pkg::VAL_W-1:0]  value,
    output logic                              done,
    output logic [oal_pkg::STAT_W-1:0]        status,
    output logic signed [oal_pkg::VAL_W-1:0]  item_out,
    output logic [oal_pkg::FIDX_W-1:0]        found_index,
    output logic [oal_pkg::COUNT_W-1:0]       count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_DOWN   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [oal_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [oal_pkg::CMP_W-1:0]     cur_reg, cur_next;
    logic                          pend_reg, pend_next;
    logic                          first_reg, first_next;
    logic [oal_pkg::IDX_W-1:0]     dst_reg, dst_next;
    logic [oal_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [oal_pkg::VAL_W-1:0]     val_reg, val_next;
    logic [oal_pkg::STAT_W-1:0]    stat_reg, stat_next;
    logic [oal_pkg::VAL_W-1:0]     item_reg, item_next;
    logic [oal_pkg::IDX_W-1:0]     fidx_reg, fidx_next;

    logic                          we, re;
    logic [oal_pkg::IDX_W-1:0]     waddr, raddr;
    logic [oal_pkg::VAL_W-1:0]     wdata, rdata;

    logic [oal_pkg::CMP_W-1:0]     cnt_ext, pos_ext, cur_dec;

    oal_ram #(
        .DEPTH (oal_pkg::CAPACITY),
        .WIDTH (oal_pkg::VAL_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cnt_ext = oal_pkg::CMP_W'(cnt_reg);
    assign pos_ext = oal_pkg::CMP_W'(pos_reg);
    assign cur_dec = cur_reg - oal_pkg::CMP_W'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        pend_next  = 1'b0;
        first_next = 1'b0;
        dst_next   = dst_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        item_next  = item_reg;
        fidx_next  = fidx_reg;
        we         = 1'b0;
        waddr      = dst_reg;
        wdata      = rdata;
        re         = 1'b0;
        raddr      = cur_reg[oal_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pos_next  = position;
                    val_next  = value;
                    stat_next = oal_pkg::ST_OK;
                    item_next = '0;
                    fidx_next = '0;
                    state_next = S_DONE;
                    case (action)
                        oal_pkg::ACT_INSERT:
                        begin
                            if (cnt_reg >= oal_pkg::CNT_W'(oal_pkg::CAPACITY))
                            begin
                                stat_next = oal_pkg::ST_FULL;
                            end
                            else if (oal_pkg::CMP_W'(position) > cnt_ext)
                            begin
                                stat_next = oal_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                cur_next   = cnt_ext;
                                state_next = S_UP;
                            end
                        end
                        oal_pkg::ACT_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = oal_pkg::ST_EMPTY;
                            end
                            else if (oal_pkg::CMP_W'(position) >= cnt_ext)
                            begin
                                stat_next = oal_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                cur_next   = oal_pkg::CMP_W'(position);
                                state_next = S_DOWN;
                            end
                        end
                        oal_pkg::ACT_SEARCH:
                        begin
                            cur_next   = '0;
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            stat_next = oal_pkg::ST_BADPOS;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // read entry cur-1, write it one place up next cycle
                we = pend_reg;
                re = (cur_reg > pos_ext);
                raddr = cur_dec[oal_pkg::IDX_W-1:0];
                if (re)
                begin
                    cur_next  = cur_dec;
                    pend_next = 1'b1;
                    dst_next  = cur_reg[oal_pkg::IDX_W-1:0];
                end
                else if (!pend_reg)
                begin
                    we         = 1'b1;
                    waddr      = oal_pkg::IDX_W'(pos_reg);
                    wdata      = val_reg;
                    cnt_next   = cnt_reg + oal_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DOWN:
            begin
                // first read is the removed entry, later ones move down one
                we = pend_reg && !first_reg;
                re = (cur_reg < cnt_ext);
                if (pend_reg && first_reg)
                begin
                    item_next = rdata;
                end
                if (re)
                begin
                    cur_next   = cur_reg + oal_pkg::CMP_W'(1);
                    pend_next  = 1'b1;
                    first_next = (cur_reg == pos_ext);
                    dst_next   = cur_dec[oal_pkg::IDX_W-1:0];
                end
                else if (!pend_reg)
                begin
                    cnt_next   = cnt_reg - oal_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_SEARCH:
            begin
                re = (cur_reg < cnt_ext);
                if (re)
                begin
                    cur_next  = cur_reg + oal_pkg::CMP_W'(1);
                    pend_next = 1'b1;
                    dst_next  = cur_reg[oal_pkg::IDX_W-1:0];
                end
                if (pend_reg && (rdata == val_reg))
                begin
                    fidx_next  = dst_reg;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (!re && !pend_reg)
                begin
                    stat_next  = oal_pkg::ST_NOTFOUND;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        dst_reg  <= dst_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        stat_reg <= stat_next;
        item_reg <= item_next;
        fidx_reg <= fidx_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign status      = stat_reg;
    assign item_out    = item_reg;
    assign found_index = oal_pkg::FIDX_W'(fidx_reg);
    assign count       = oal_pkg::COUNT_W'(cnt_reg);

endmodule
